// ----- src/pst_pkg.sv -----
// Shared types and constants for the pulse stream tag checker.
// No dependencies.
package pst_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned GATE_W   = 9;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned LEN_W    = 12;
	localparam int unsigned SEQ_W    = 30;
	localparam int unsigned CHAN_W   = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 9;

	// integrated frames open with this many tag words
	localparam logic [LEN_W-1:0] INT_TAGS = LEN_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_ID = 2'd0,
		CFG_GATE_COUNT = 2'd1,
		CFG_INTEGRATED = 2'd2,
		CFG_FREE_RUN   = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_TAG      = 2'd0,
		KIND_PLAIN_IQ = 2'd1,
		KIND_EVEN     = 2'd2,
		KIND_ODD      = 2'd3
	} word_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_CHAN_MISS = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_REPEAT    = 3'd3,
		ST_KEY_MISS  = 3'd4
	} tag_status_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel_id;
		logic [GATE_W-1:0] gate_count;
		logic              integrated;
		logic              free_run;
	} cfg_t;

endpackage

// ----- src/pulse_stream_tag_checker.sv -----
// Pulse stream tag checker top level: input register, frame tracking and
// tag checks, result register. Depends on pst_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/stream_word) takes one 32-bit word of
//   the receiver stream. Output channel (out_valid/out_ready and the result
//   fields) returns one result word per input word, in order.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
//   the user must write it only while no words are in flight; the block does not enforce this.
//   Path: an accepted word is held in the input register, checked, and
//   written to the result register. Throughput: one word per cycle while
//   the output is not stalled, set by the frame position and sequence
//   update computed between the input register and the result register.
//   Reset: clears the frame position, last sequence and both counters, arms
//   first-tag acceptance, and loads gate_count 1 with the other config fields 0.
//   Stall: while out_ready is low the result holds; one more word is taken
//   into the input register, then in_ready drops until the result is taken.
module pulse_stream_tag_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pst_pkg::WORD_W-1:0]         stream_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         word_kind,
	output logic [2:0]                         tag_status,
	output logic [pst_pkg::GATE_W-1:0]         gate_index,
	output logic [pst_pkg::COUNT_W-1:0]        dropped_total,
	output logic [pst_pkg::COUNT_W-1:0]        sync_error_total,
	input  logic                               cfg_wr_en,
	input  logic [pst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pst_pkg::cfg_t cfg_q;

	logic                           valid_s1;
	logic [pst_pkg::WORD_W-1:0]     word_s1;
	logic                           advance;

	logic [pst_pkg::POS_W-1:0]      frame_pos_q;
	logic [pst_pkg::SEQ_W-1:0]      last_seq_q;
	logic                           await_first_q;
	logic [pst_pkg::COUNT_W-1:0]    dropped_q;
	logic [pst_pkg::COUNT_W-1:0]    sync_err_q;

	logic [pst_pkg::GATE_W-1:0]     gates;
	logic [pst_pkg::LEN_W-1:0]      gates2;
	logic [pst_pkg::LEN_W-1:0]      frame_len;
	logic [pst_pkg::LEN_W-1:0]      pos;
	logic [pst_pkg::LEN_W-1:0]      pos_inc;
	logic [pst_pkg::LEN_W-1:0]      even_off;
	logic [pst_pkg::LEN_W-1:0]      odd_off;
	logic [pst_pkg::CHAN_W-1:0]     tag_chan;
	logic [pst_pkg::SEQ_W-1:0]      tag_seq;
	logic [pst_pkg::SEQ_W:0]        seq_next;
	logic [3:0]                     key_exp;

	pst_pkg::word_kind_t            kind_d;
	pst_pkg::tag_status_t           status_d;
	logic [pst_pkg::GATE_W-1:0]     gate_d;
	logic                           bump_drop;
	logic                           bump_sync;
	logic                           seq_load;
	logic [pst_pkg::POS_W-1:0]      pos_next;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_id <= '0;
			cfg_q.gate_count <= pst_pkg::GATE_W'(1);
			cfg_q.integrated <= 1'b0;
			cfg_q.free_run   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pst_pkg::CFG_CHANNEL_ID: cfg_q.channel_id <= cfg_data[pst_pkg::CHAN_W-1:0];
				pst_pkg::CFG_GATE_COUNT: cfg_q.gate_count <= cfg_data[pst_pkg::GATE_W-1:0];
				pst_pkg::CFG_INTEGRATED: cfg_q.integrated <= cfg_data[0];
				pst_pkg::CFG_FREE_RUN:   cfg_q.free_run   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= stream_word;
		end
	end

	always_comb begin
		// zero gate count runs as one gate; 9 bits cannot exceed the maximum
		gates  = (cfg_q.gate_count == '0) ? pst_pkg::GATE_W'(1) : cfg_q.gate_count;
		gates2 = {2'b00, gates, 1'b0};

		if (cfg_q.integrated)
			frame_len = pst_pkg::INT_TAGS + {1'b0, gates, 2'b00};
		else if (cfg_q.free_run)
			frame_len = {3'b000, gates};
		else
			frame_len = {3'b000, gates} + pst_pkg::LEN_W'(1);

		// a position left past the end by a config change restarts the frame
		pos = {1'b0, frame_pos_q};
		if (pos >= frame_len)
			pos = '0;

		pos_inc  = pos + pst_pkg::LEN_W'(1);
		pos_next = (pos_inc >= frame_len) ? '0 : pos_inc[pst_pkg::POS_W-1:0];

		even_off = pos - pst_pkg::INT_TAGS;
		odd_off  = even_off - gates2;

		tag_chan = word_s1[31:30];
		tag_seq  = word_s1[pst_pkg::SEQ_W-1:0];
		// no wrap: the top sequence plus one never matches a 30-bit value
		seq_next = {1'b0, last_seq_q} + (pst_pkg::SEQ_W+1)'(1);
		key_exp  = {cfg_q.channel_id, pos[1:0]};

		kind_d    = pst_pkg::KIND_TAG;
		status_d  = pst_pkg::ST_OK;
		gate_d    = '0;
		bump_drop = 1'b0;
		bump_sync = 1'b0;
		seq_load  = 1'b0;

		if (cfg_q.integrated) begin
			if (pos < pst_pkg::INT_TAGS) begin
				if (word_s1[27:24] != key_exp) begin
					status_d  = pst_pkg::ST_KEY_MISS;
					bump_sync = 1'b1;
				end
			end else if (pos < pst_pkg::INT_TAGS + gates2) begin
				kind_d = pst_pkg::KIND_EVEN;
				gate_d = even_off[pst_pkg::GATE_W:1];
			end else begin
				kind_d = pst_pkg::KIND_ODD;
				gate_d = odd_off[pst_pkg::GATE_W:1];
			end
		end else if (cfg_q.free_run) begin
			kind_d = pst_pkg::KIND_PLAIN_IQ;
			gate_d = pos[pst_pkg::GATE_W-1:0];
		end else if (pos == '0) begin
			if (tag_chan != cfg_q.channel_id) begin
				status_d  = pst_pkg::ST_CHAN_MISS;
				bump_sync = 1'b1;
			end else begin
				seq_load = 1'b1;
				if (await_first_q) begin
					status_d = pst_pkg::ST_OK;
				end else if ({1'b0, tag_seq} == seq_next) begin
					status_d = pst_pkg::ST_OK;
				end else if (tag_seq == last_seq_q) begin
					status_d  = pst_pkg::ST_REPEAT;
					bump_sync = 1'b1;
				end else begin
					status_d  = pst_pkg::ST_DROPPED;
					bump_drop = 1'b1;
				end
			end
		end else begin
			kind_d = pst_pkg::KIND_PLAIN_IQ;
			gate_d = pos[pst_pkg::GATE_W-1:0] - pst_pkg::GATE_W'(1);
		end
	end

	// frame state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q   <= '0;
			last_seq_q    <= '0;
			await_first_q <= 1'b1;
			dropped_q     <= '0;
			sync_err_q    <= '0;
		end else if (advance) begin
			frame_pos_q <= pos_next;
			if (seq_load) begin
				last_seq_q    <= tag_seq;
				await_first_q <= 1'b0;
			end
			if (bump_drop && (dropped_q != '1))
				dropped_q <= dropped_q + pst_pkg::COUNT_W'(1);
			if (bump_sync && (sync_err_q != '1))
				sync_err_q <= sync_err_q + pst_pkg::COUNT_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_kind  <= kind_d;
			tag_status <= status_d;
			gate_index <= gate_d;
			dropped_total    <= (bump_drop && (dropped_q != '1)) ?
				dropped_q + pst_pkg::COUNT_W'(1) : dropped_q;
			sync_error_total <= (bump_sync && (sync_err_q != '1)) ?
				sync_err_q + pst_pkg::COUNT_W'(1) : sync_err_q;
		end
	end

endmodule
